### rtl/mii_pkg.sv
// Shared constants for the metric inverse interpolation block.
package mii_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MUL_CHUNK      = 32;
    localparam int THR_WIDTH      = 32;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd4295;

    localparam int ST_WIDTH = 2;
    localparam logic [ST_WIDTH-1:0] ST_OK   = 2'd0;
    localparam logic [ST_WIDTH-1:0] ST_NONE = 2'd1;
    localparam logic [ST_WIDTH-1:0] ST_SING = 2'd2;
    localparam logic [ST_WIDTH-1:0] ST_SAT  = 2'd3;
endpackage

### rtl/mii_mul.sv
// Pipelined signed multiplier: one chunk of the B operand per stage, tag travels alongside.
module mii_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int CW = 32,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic signed [AW+BW-1:0] o_p,
    output logic [TW-1:0]        o_tag
);
    localparam int NS = (BW + CW - 1) / CW;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int PW = AW + BW;
    localparam int AP = NA * CW;
    localparam int BP = NS * CW;

    logic [NS:0]    r_v;
    logic           r_vo;
    logic [AP-1:0]  r_a   [NS];
    logic [BP-1:0]  r_b   [NS];
    logic           r_s   [NS+1];
    logic [PW-1:0]  r_acc [NS+1];
    logic [TW-1:0]  r_t   [NS+1];
    logic signed [PW-1:0] r_p;
    logic [TW-1:0]  r_to;
    logic [AW-1:0]  n_am;
    logic [BW-1:0]  n_bm;

    assign n_am = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign n_bm = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v  <= {r_v[NS-1:0], i_valid};
            r_vo <= r_v[NS];
        end
    end

    // work on magnitudes, sign goes on at the end
    always_ff @(posedge i_clk) begin
        r_a[0]   <= AP'(n_am);
        r_b[0]   <= BP'(n_bm);
        r_s[0]   <= i_a[AW-1] ^ i_b[BW-1];
        r_acc[0] <= '0;
        r_t[0]   <= i_tag;
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [2*CW-1:0] n_pp [NA];
        logic [PW-1:0]   n_ev, n_od;

        for (genvar j = 0; j < NA; j++) begin : g_pp
            assign n_pp[j] = (2*CW)'(r_a[s][j*CW +: CW]) * (2*CW)'(r_b[s][s*CW +: CW]);
        end

        // even and odd partial products never overlap, so each row is a plain merge
        always_comb begin
            n_ev = '0;
            n_od = '0;
            for (int j = 0; j < NA; j++) begin
                if ((j & 1) == 0) begin
                    n_ev = n_ev | (PW'(n_pp[j]) << (j * CW));
                end else begin
                    n_od = n_od | (PW'(n_pp[j]) << (j * CW));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_s[s+1]   <= r_s[s];
            r_t[s+1]   <= r_t[s];
            r_acc[s+1] <= r_acc[s] + ((n_ev + n_od) << (s * CW));
        end

        if (s + 1 < NS) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_a[s+1] <= r_a[s];
                r_b[s+1] <= r_b[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= r_s[NS] ? -$signed(r_acc[NS]) : $signed(r_acc[NS]);
        r_to <= r_t[NS];
    end

    assign o_valid = r_vo;
    assign o_p     = r_p;
    assign o_tag   = r_to;
endmodule

### rtl/mii_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating and saturating.
module mii_div #(
    parameter int NW = 64,
    parameter int DW = 64,
    parameter int QW = 32,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic signed [QW-1:0] o_q,
    output logic                 o_sat,
    output logic [TW-1:0]        o_tag
);
    localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;
    localparam logic [QW-1:0] LIM = QW'(1) << (QW - 1);

    logic [QW:0]    r_v;
    logic           r_vo;
    logic [RW-1:0]  r_rem [QW+1];
    logic [RW-1:0]  r_den [QW+1];
    logic [QW-1:0]  r_qt  [QW+1];
    logic           r_neg [QW+1];
    logic           r_big [QW+1];
    logic [TW-1:0]  r_t   [QW+1];
    logic signed [QW-1:0] r_q;
    logic           r_sat;
    logic [TW-1:0]  r_to;
    logic signed [RW-1:0] n_nx, n_dx;
    logic [RW-1:0]  n_nm, n_dm;
    logic           n_sat;
    logic [QW-1:0]  n_mag;

    assign n_nx = RW'(i_num);
    assign n_dx = RW'(i_den);
    assign n_nm = n_nx[RW-1] ? RW'(-n_nx) : RW'(n_nx);
    assign n_dm = n_dx[RW-1] ? RW'(-n_dx) : RW'(n_dx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v  <= {r_v[QW-1:0], i_valid};
            r_vo <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_nm;
        r_den[0] <= n_dm;
        r_qt[0]  <= '0;
        r_neg[0] <= i_num[NW-1] ^ i_den[DW-1];
        r_big[0] <= n_nm >= (n_dm << QW);
        r_t[0]   <= i_tag;
    end

    for (genvar i = 0; i < QW; i++) begin : g_bit
        logic [RW-1:0] n_try;
        logic          n_ge;
        assign n_try = r_den[i] << (QW - 1 - i);
        assign n_ge  = r_rem[i] >= n_try;
        always_ff @(posedge i_clk) begin
            r_rem[i+1] <= n_ge ? r_rem[i] - n_try : r_rem[i];
            r_qt[i+1]  <= r_qt[i] | (QW'(n_ge) << (QW - 1 - i));
            r_den[i+1] <= r_den[i];
            r_neg[i+1] <= r_neg[i];
            r_big[i+1] <= r_big[i];
            r_t[i+1]   <= r_t[i];
        end
    end

    always_comb begin
        if (r_neg[QW]) begin
            n_sat = r_big[QW] || (r_qt[QW] > LIM);
            n_mag = n_sat ? LIM : r_qt[QW];
        end else begin
            n_sat = r_big[QW] || (r_qt[QW] > LIM - QW'(1));
            n_mag = n_sat ? LIM - QW'(1) : r_qt[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= r_neg[QW] ? -$signed(n_mag) : $signed(n_mag);
        r_sat <= n_sat;
        r_to  <= r_t[QW];
    end

    assign o_valid = r_vo;
    assign o_q     = r_q;
    assign o_sat   = r_sat;
    assign o_tag   = r_to;
endmodule

### rtl/metric_inverse_interpolation.sv
// Weighted inverse-domain interpolation of three 2x2 metrics, fully pipelined.
// o_done is registered from the divider outputs; each multiplier has ceil(width/32) stages,
// one per 32-bit chunk of its B operand.
// Throughput: one item per cycle, every cycle; busy stays low and results cannot be held.
// Reset clears all valid bits and loads the threshold register r_thr with 4295.
module metric_inverse_interpolation #(
    parameter int DATA_WIDTH = mii_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mii_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_first_xx,
    input  logic signed [DATA_WIDTH-1:0] i_first_xy,
    input  logic signed [DATA_WIDTH-1:0] i_first_yy,
    input  logic signed [DATA_WIDTH-1:0] i_second_xx,
    input  logic signed [DATA_WIDTH-1:0] i_second_xy,
    input  logic signed [DATA_WIDTH-1:0] i_second_yy,
    input  logic signed [DATA_WIDTH-1:0] i_third_xx,
    input  logic signed [DATA_WIDTH-1:0] i_third_xy,
    input  logic signed [DATA_WIDTH-1:0] i_third_yy,
    input  logic signed [DATA_WIDTH-1:0] i_weight_first,
    input  logic signed [DATA_WIDTH-1:0] i_weight_second,
    input  logic signed [DATA_WIDTH-1:0] i_weight_third,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_result_xx,
    output logic signed [DATA_WIDTH-1:0] o_result_xy,
    output logic signed [DATA_WIDTH-1:0] o_result_yy,
    output logic [mii_pkg::ST_WIDTH-1:0] o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mii_pkg::THR_WIDTH-1:0] i_cfg_data
);
    import mii_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int DTW  = 2 * W + 1;     // determinant
    localparam int EW   = 2 * DTW;       // product of two determinants
    localparam int FW   = 3 * DTW;       // weight factor and full product
    localparam int TMW  = FW + W;        // one term of a sum
    localparam int SW   = TMW + 2;       // sum of three terms
    localparam int SQW  = 2 * SW;        // sum times sum
    localparam int NPW  = FW + SW;       // product times sum
    localparam int DETW = SQW + 1;
    localparam int NW   = NPW + FRAC_BITS + 1;

    typedef struct packed {
        logic signed [W-1:0] xx;
        logic signed [W-1:0] xy;
        logic signed [W-1:0] yy;
    } t_mat;

    typedef struct packed {
        t_mat [2:0]         m;
        logic [2:0][W-1:0]  w;
    } t_tag1;

    typedef struct packed {
        logic               any;
        logic [DTW-1:0]     d0;
        logic [2:0][W-1:0]  w;
        t_mat [2:0]         m;
    } t_tag2;

    typedef struct packed {
        logic       any;
        t_mat [2:0] m;
    } t_tag3;

    typedef struct packed {
        logic          any;
        logic [FW-1:0] prod;
    } t_tag4;

    typedef struct packed {
        logic any;
        logic sing;
    } t_tag6;

    logic [THR_WIDTH-1:0] r_thr;
    t_mat [2:0]           n_m;
    logic [2:0][W-1:0]    n_w;
    t_tag1                n_tag1;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    assign n_m[0] = '{xx: i_first_xx,  xy: i_first_xy,  yy: i_first_yy};
    assign n_m[1] = '{xx: i_second_xx, xy: i_second_xy, yy: i_second_yy};
    assign n_m[2] = '{xx: i_third_xx,  xy: i_third_xy,  yy: i_third_yy};
    assign n_w[0] = i_weight_first;
    assign n_w[1] = i_weight_second;
    assign n_w[2] = i_weight_third;
    assign n_tag1 = '{m: n_m, w: n_w};

    // determinants: xx*yy and xy*xy
    logic                    g1_v   [3];
    t_tag1                   g1_t   [3];
    logic signed [2*W-1:0]   g1_p   [3];
    logic signed [2*W-1:0]   g1_q   [3];

    for (genvar k = 0; k < 3; k++) begin : g_det
        mii_mul #(.AW(W), .BW(W), .CW(MUL_CHUNK), .TW($bits(t_tag1))) u_pq (
            .i_clk, .i_rst_n, .i_valid(start && !busy),
            .i_a(n_m[k].xx), .i_b(n_m[k].yy), .i_tag(n_tag1),
            .o_valid(g1_v[k]), .o_p(g1_p[k]), .o_tag(g1_t[k])
        );
        mii_mul #(.AW(W), .BW(W), .CW(MUL_CHUNK), .TW(1)) u_qq (
            .i_clk, .i_rst_n, .i_valid(start && !busy),
            .i_a(n_m[k].xy), .i_b(n_m[k].xy), .i_tag(1'b0),
            .o_valid(), .o_p(g1_q[k]), .o_tag()
        );
    end

    // keep or drop each metric; a dropped one counts as det 1, weight 0
    logic                    r_a_v;
    logic signed [DTW-1:0]   r_a_d [3];
    logic [2:0][W-1:0]       r_a_w;
    logic                    r_a_any;
    t_mat [2:0]              r_a_m;
    logic signed [DTW-1:0]   n_det  [3];
    logic [2:0]              n_kept;
    logic [2:0]              n_live;

    for (genvar k = 0; k < 3; k++) begin : g_keep
        assign n_det[k]  = DTW'(g1_p[k]) - DTW'(g1_q[k]);
        assign n_kept[k] = !n_det[k][DTW-1] && (n_det[k] != '0)
                         && ($unsigned(n_det[k]) >= DTW'(r_thr));
        assign n_live[k] = n_kept[k] && (g1_t[0].w[k] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= g1_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_any <= |n_live;
        r_a_m   <= g1_t[0].m;
        for (int k = 0; k < 3; k++) begin
            r_a_d[k] <= n_kept[k] ? n_det[k] : DTW'(1);
            r_a_w[k] <= n_kept[k] ? g1_t[0].w[k] : '0;
        end
    end

    // products of the other two determinants
    t_tag2                 n_tag2;
    logic                  g2_v [3];
    t_tag2                 g2_t [3];
    logic signed [EW-1:0]  g2_e [3];

    assign n_tag2 = '{any: r_a_any, d0: r_a_d[0], w: r_a_w, m: r_a_m};

    for (genvar k = 0; k < 3; k++) begin : g_pair
        mii_mul #(.AW(DTW), .BW(DTW), .CW(MUL_CHUNK), .TW($bits(t_tag2))) u_e (
            .i_clk, .i_rst_n, .i_valid(r_a_v),
            .i_a(r_a_d[(k == 0) ? 1 : 0]), .i_b(r_a_d[(k == 2) ? 1 : 2]), .i_tag(n_tag2),
            .o_valid(g2_v[k]), .o_p(g2_e[k]), .o_tag(g2_t[k])
        );
    end

    // weight factors and the full determinant product
    t_tag3                 n_tag3;
    logic                  g3_v [3];
    t_tag3                 g3_t [3];
    logic signed [FW-1:0]  g3_f [3];
    logic signed [FW-1:0]  g3_prod;

    assign n_tag3 = '{any: g2_t[0].any, m: g2_t[0].m};

    for (genvar k = 0; k < 3; k++) begin : g_fac
        mii_mul #(.AW(EW), .BW(DTW), .CW(MUL_CHUNK), .TW($bits(t_tag3))) u_f (
            .i_clk, .i_rst_n, .i_valid(g2_v[0]),
            .i_a(g2_e[k]), .i_b(DTW'($signed(g2_t[0].w[k]))), .i_tag(n_tag3),
            .o_valid(g3_v[k]), .o_p(g3_f[k]), .o_tag(g3_t[k])
        );
    end

    mii_mul #(.AW(EW), .BW(DTW), .CW(MUL_CHUNK), .TW(1)) u_prod (
        .i_clk, .i_rst_n, .i_valid(g2_v[0]),
        .i_a(g2_e[0]), .i_b($signed(g2_t[0].d0)), .i_tag(1'b0),
        .o_valid(), .o_p(g3_prod), .o_tag()
    );

    // weighted adjugate terms
    t_tag4                 n_tag4;
    logic                  g4_v  [3];
    t_tag4                 g4_t  [3];
    logic signed [TMW-1:0] g4_xx [3];
    logic signed [TMW-1:0] g4_xy [3];
    logic signed [TMW-1:0] g4_yy [3];

    assign n_tag4 = '{any: g3_t[0].any, prod: g3_prod};

    for (genvar k = 0; k < 3; k++) begin : g_term
        mii_mul #(.AW(FW), .BW(W), .CW(MUL_CHUNK), .TW($bits(t_tag4))) u_xx (
            .i_clk, .i_rst_n, .i_valid(g3_v[0]),
            .i_a(g3_f[k]), .i_b(g3_t[0].m[k].xx), .i_tag(n_tag4),
            .o_valid(g4_v[k]), .o_p(g4_xx[k]), .o_tag(g4_t[k])
        );
        mii_mul #(.AW(FW), .BW(W), .CW(MUL_CHUNK), .TW(1)) u_xy (
            .i_clk, .i_rst_n, .i_valid(g3_v[0]),
            .i_a(g3_f[k]), .i_b(g3_t[0].m[k].xy), .i_tag(1'b0),
            .o_valid(), .o_p(g4_xy[k]), .o_tag()
        );
        mii_mul #(.AW(FW), .BW(W), .CW(MUL_CHUNK), .TW(1)) u_yy (
            .i_clk, .i_rst_n, .i_valid(g3_v[0]),
            .i_a(g3_f[k]), .i_b(g3_t[0].m[k].yy), .i_tag(1'b0),
            .o_valid(), .o_p(g4_yy[k]), .o_tag()
        );
    end

    // sum of weighted inverses, scaled by the determinant product
    logic                 r_c_v;
    logic                 r_c_any;
    logic signed [SW-1:0] r_c_sxx, r_c_sxy, r_c_syy;
    logic signed [FW-1:0] r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= g4_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sxx  <= SW'(g4_yy[0]) + SW'(g4_yy[1]) + SW'(g4_yy[2]);
        r_c_sxy  <= -(SW'(g4_xy[0]) + SW'(g4_xy[1]) + SW'(g4_xy[2]));
        r_c_syy  <= SW'(g4_xx[0]) + SW'(g4_xx[1]) + SW'(g4_xx[2]);
        r_c_prod <= $signed(g4_t[0].prod);
        r_c_any  <= g4_t[0].any;
    end

    // determinant of the sum and the three numerators
    logic                  g5_v;
    logic                  g5_any;
    logic signed [SQW-1:0] g5_ss, g5_xy2;
    logic signed [NPW-1:0] g5_nxx, g5_nxy, g5_nyy;

    mii_mul #(.AW(SW), .BW(SW), .CW(MUL_CHUNK), .TW(1)) u_ss (
        .i_clk, .i_rst_n, .i_valid(r_c_v),
        .i_a(r_c_sxx), .i_b(r_c_syy), .i_tag(r_c_any),
        .o_valid(g5_v), .o_p(g5_ss), .o_tag(g5_any)
    );
    mii_mul #(.AW(SW), .BW(SW), .CW(MUL_CHUNK), .TW(1)) u_xy2 (
        .i_clk, .i_rst_n, .i_valid(r_c_v),
        .i_a(r_c_sxy), .i_b(r_c_sxy), .i_tag(1'b0),
        .o_valid(), .o_p(g5_xy2), .o_tag()
    );
    mii_mul #(.AW(FW), .BW(SW), .CW(MUL_CHUNK), .TW(1)) u_nxx (
        .i_clk, .i_rst_n, .i_valid(r_c_v),
        .i_a(r_c_prod), .i_b(r_c_syy), .i_tag(1'b0),
        .o_valid(), .o_p(g5_nxx), .o_tag()
    );
    mii_mul #(.AW(FW), .BW(SW), .CW(MUL_CHUNK), .TW(1)) u_nxy (
        .i_clk, .i_rst_n, .i_valid(r_c_v),
        .i_a(r_c_prod), .i_b(r_c_sxy), .i_tag(1'b0),
        .o_valid(), .o_p(g5_nxy), .o_tag()
    );
    mii_mul #(.AW(FW), .BW(SW), .CW(MUL_CHUNK), .TW(1)) u_nyy (
        .i_clk, .i_rst_n, .i_valid(r_c_v),
        .i_a(r_c_prod), .i_b(r_c_sxx), .i_tag(1'b0),
        .o_valid(), .o_p(g5_nyy), .o_tag()
    );

    logic                   r_d_v;
    t_tag6                  r_d_tag;
    logic signed [DETW-1:0] r_d_det;
    logic signed [NW-1:0]   r_d_nxx, r_d_nxy, r_d_nyy;
    logic signed [DETW-1:0] n_sdet;

    assign n_sdet = DETW'(g5_ss) - DETW'(g5_xy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= g5_v;
        end
    end

    // off-diagonal of the inverse flips sign
    always_ff @(posedge i_clk) begin
        r_d_det <= n_sdet;
        r_d_nxx <= NW'(g5_nxx) <<< FRAC_BITS;
        r_d_nxy <= (-NW'(g5_nxy)) <<< FRAC_BITS;
        r_d_nyy <= NW'(g5_nyy) <<< FRAC_BITS;
        r_d_tag <= '{any: g5_any, sing: (n_sdet == '0)};
    end

    // final divisions
    logic                g6_v;
    t_tag6               g6_t;
    logic signed [W-1:0] g6_qxx, g6_qxy, g6_qyy;
    logic                g6_sxx, g6_sxy, g6_syy;

    mii_div #(.NW(NW), .DW(DETW), .QW(W), .TW($bits(t_tag6))) u_dxx (
        .i_clk, .i_rst_n, .i_valid(r_d_v),
        .i_num(r_d_nxx), .i_den(r_d_det), .i_tag(r_d_tag),
        .o_valid(g6_v), .o_q(g6_qxx), .o_sat(g6_sxx), .o_tag(g6_t)
    );
    mii_div #(.NW(NW), .DW(DETW), .QW(W), .TW(1)) u_dxy (
        .i_clk, .i_rst_n, .i_valid(r_d_v),
        .i_num(r_d_nxy), .i_den(r_d_det), .i_tag(1'b0),
        .o_valid(), .o_q(g6_qxy), .o_sat(g6_sxy), .o_tag()
    );
    mii_div #(.NW(NW), .DW(DETW), .QW(W), .TW(1)) u_dyy (
        .i_clk, .i_rst_n, .i_valid(r_d_v),
        .i_num(r_d_nyy), .i_den(r_d_det), .i_tag(1'b0),
        .o_valid(), .o_q(g6_qyy), .o_sat(g6_syy), .o_tag()
    );

    logic                r_o_v;
    logic signed [W-1:0] r_o_xx, r_o_xy, r_o_yy;
    logic [ST_WIDTH-1:0] r_o_st;
    logic                n_ok;

    assign n_ok = g6_t.any && !g6_t.sing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= g6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_xx <= n_ok ? g6_qxx : '0;
        r_o_xy <= n_ok ? g6_qxy : '0;
        r_o_yy <= n_ok ? g6_qyy : '0;
        if (!g6_t.any) begin
            r_o_st <= ST_NONE;
        end else if (g6_t.sing) begin
            r_o_st <= ST_SING;
        end else if (g6_sxx || g6_sxy || g6_syy) begin
            r_o_st <= ST_SAT;
        end else begin
            r_o_st <= ST_OK;
        end
    end

    assign o_done      = r_o_v;
    assign o_result_xx = r_o_xx;
    assign o_result_xy = r_o_xy;
    assign o_result_yy = r_o_yy;
    assign o_status    = r_o_st;

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_NONE || o_status == ST_SING)
        |-> o_result_xx == '0 && o_result_xy == '0 && o_result_yy == '0)
        else $error("excluded or singular item carries a nonzero result");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_SAT
        |-> o_result_xx == SMAX || o_result_xx == SMIN || o_result_xy == SMAX
            || o_result_xy == SMIN || o_result_yy == SMAX || o_result_yy == SMIN)
        else $error("saturated status with no entry at a bound");

    a_done_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(g6_v))
        else $error("result strobe without a divider result");
endmodule
